@@ src/fhs_pkg.sv @@
// ----------------------------------------------------------------------------
// fhs_pkg: shared types and constants of the fire heat strip effect
// Holds the sequencer states, register indexes, arithmetic constants and the
// color ramp used to turn a scaled heat value into one RGB pixel.
// ----------------------------------------------------------------------------
package fhs_pkg;

  localparam int unsigned HEAT_W   = 8;
  localparam int unsigned LFSR_W   = 16;
  localparam int unsigned MUL_W    = 16;
  localparam int unsigned PROD_W   = 32;
  localparam int unsigned COOL_W   = 10;
  localparam int unsigned CHANCE_W = 9;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned PIX_IDX_W = 6;
  localparam int unsigned DIVD_W   = 14;
  localparam int unsigned MAXC_W   = 11;

  localparam logic [LFSR_W-1:0] LFSR_MASK  = 16'hB400;
  localparam logic [3:0]        COOL_SCALE = 4'd10;
  // (v * 683) >> 11 equals v / 3 for every v up to 765.
  localparam logic [MUL_W-1:0]  RECIP3     = 16'd683;
  // (x * 32897) >> 23 equals x / 255 for every 16-bit x.
  localparam logic [MUL_W-1:0]  RECIP255   = 16'd32897;
  localparam logic [MUL_W-1:0]  HEAT_GAIN  = 16'd191;
  localparam logic [MUL_W-1:0]  HEAT_ROUND = 16'd127;
  localparam logic [7:0]        T_HIGH     = 8'h80;
  localparam logic [7:0]        T_MID      = 8'h40;
  localparam logic [5:0]        RAMP_MASK  = 6'h3F;

  localparam logic [CFG_IDX_W-1:0] REG_COOLING_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPARK_CHANCE = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_COOL_MUL,
    ST_COOL_SUB,
    ST_COOL_WR,
    ST_OUT_MUL,
    ST_OUT_RCP,
    ST_OUT_EMIT
  } state_t;

  typedef struct packed {
    logic              shift;
    logic [HEAT_W-1:0] value;
  } row_ctl_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] n;
    n = {1'b0, s[LFSR_W-1:1]};
    if (s[0]) begin
      n = n ^ LFSR_MASK;
    end
    return n;
  endfunction

  function automatic rgb_t heat_rgb(input logic [7:0] t);
    rgb_t       c;
    logic [7:0] ramp;
    ramp = {t[5:0] & RAMP_MASK, 2'b00};
    if (t > T_HIGH) begin
      c = '{red: 8'hFF, green: 8'hFF, blue: ramp};
    end else if (t > T_MID) begin
      c = '{red: 8'hFF, green: ramp, blue: 8'h00};
    end else begin
      c = '{red: ramp, green: 8'h00, blue: 8'h00};
    end
    return c;
  endfunction

endpackage

@@ src/fire_heat_strip_effect_core.sv @@
// ----------------------------------------------------------------------------
// fire_heat_strip_effect_core: fire effect over a row of heat cells
// Each start word runs one frame: random cooling with upward diffusion,
// an optional spark, then one RGB pixel word per cell.
//
//   channel  direction  handshake            payload
//   in_      input      start / busy         spark_roll, spark_cell,
//                                            spark_heat, cool_seed
//   out_     output     out_valid (strobe)   pixel_index, red, green, blue,
//                                            last_pixel
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A frame holds busy through ST_DIV for the cooldown limit, then through the
// cooling steps ST_COOL_MUL, ST_COOL_SUB, ST_COOL_WR per cell and the output
// steps ST_OUT_MUL, ST_OUT_RCP, ST_OUT_EMIT per cell, each paced by the one
// shared multiplier. The last pixel word is shown in the cycle busy falls.
// Synchronous active-low reset clears the cells and restores the registers.
// The receiver cannot stall; each pixel word is shown for one cycle.
// ----------------------------------------------------------------------------
module fire_heat_strip_effect_core
  import fhs_pkg::*;
#(
  parameter int unsigned NUM_CELLS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [7:0]            in_spark_roll,
  input  logic [2:0]            in_spark_cell,
  input  logic [7:0]            in_spark_heat,
  input  logic [15:0]           in_cool_seed,
  output logic                  out_valid,
  output logic [PIX_IDX_W-1:0]  out_pixel_index,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic                  out_last_pixel,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned IDX_W = $clog2(NUM_CELLS);

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  logic [COOL_W-1:0]   cooling_rate_r, cooling_rate_nxt;
  logic [CHANCE_W-1:0] spark_chance_r, spark_chance_nxt;
  logic [LFSR_W-1:0]   lfsr_r, lfsr_nxt;
  logic [MAXC_W-1:0]   mc1_r, mc1_nxt;
  logic [HEAT_W-1:0]   cool_r, cool_nxt;
  logic [HEAT_W-1:0]   p1_r, p1_nxt;
  logic [HEAT_W-1:0]   p2_r, p2_nxt;
  logic                spark_en_r, spark_en_nxt;
  logic [2:0]          cell_r, cell_nxt;
  logic [7:0]          sheat_r, sheat_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [PIX_IDX_W-1:0] pix_r, pix_nxt;
  rgb_t                rgb_r, rgb_nxt;
  logic                last_r, last_nxt;

  logic                accept;
  logic                div_done;
  logic [DIVD_W-1:0]   div_quot;
  logic [DIVD_W-1:0]   div_dividend;
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0]   mul_prod;
  row_ctl_t            row_ctl;
  logic [HEAT_W-1:0]   head;
  logic [MAXC_W-1:0]   draw;
  logic [HEAT_W:0]     spark_sum;
  logic [HEAT_W-1:0]   spark_val;
  logic                is_last;

  assign accept       = start && !busy;
  assign busy         = (state_r != ST_IDLE);
  assign cfg_ready    = !busy;
  assign div_dividend = DIVD_W'(cooling_rate_r) * DIVD_W'(COOL_SCALE);
  assign is_last      = (cnt_r == IDX_W'(NUM_CELLS - 1));

  fhs_div #(
    .DIVISOR (NUM_CELLS),
    .DW      (DIVD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .dividend (div_dividend),
    .done     (div_done),
    .quotient (div_quot)
  );

  fhs_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_prod)
  );

  fhs_heat_row #(
    .NUM_CELLS (NUM_CELLS)
  ) u_row (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (row_ctl),
    .head  (head)
  );

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    cooling_rate_nxt = cooling_rate_r;
    spark_chance_nxt = spark_chance_r;
    lfsr_nxt         = lfsr_r;
    mc1_nxt          = mc1_r;
    cool_nxt         = cool_r;
    p1_nxt           = p1_r;
    p2_nxt           = p2_r;
    spark_en_nxt     = spark_en_r;
    cell_nxt         = cell_r;
    sheat_nxt        = sheat_r;
    out_valid_nxt    = 1'b0;
    pix_nxt          = pix_r;
    rgb_nxt          = rgb_r;
    last_nxt         = last_r;
    mul_a            = '0;
    mul_b            = '0;
    row_ctl          = '{shift: 1'b0, value: '0};
    draw             = mul_prod[26:16];
    spark_sum        = {1'b0, head} + {1'b0, sheat_r};
    spark_val        = head;
    if (spark_en_r && (cnt_r == IDX_W'(cell_r))) begin
      spark_val = spark_sum[HEAT_W] ? 8'hFF : spark_sum[HEAT_W-1:0];
    end

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COOLING_RATE: cooling_rate_nxt = cfg_data[COOL_W-1:0];
        REG_SPARK_CHANCE: spark_chance_nxt = cfg_data[CHANCE_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          lfsr_nxt     = in_cool_seed;
          spark_en_nxt = ({1'b0, in_spark_roll} < spark_chance_r);
          cell_nxt     = in_spark_cell;
          sheat_nxt    = in_spark_heat;
          cnt_nxt      = '0;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          // The limit plus one: quotient + 2 + 1.
          mc1_nxt   = div_quot[MAXC_W-1:0] + MAXC_W'(3);
          state_nxt = ST_COOL_MUL;
        end
      end
      ST_COOL_MUL: begin
        lfsr_nxt  = lfsr_step(lfsr_r);
        mul_a     = lfsr_nxt;
        mul_b     = MUL_W'(mc1_r);
        state_nxt = ST_COOL_SUB;
      end
      ST_COOL_SUB: begin
        cool_nxt  = (draw > MAXC_W'(head)) ? '0 : (head - draw[HEAT_W-1:0]);
        // Diffusion uses the cooled values of the two cells below.
        mul_a     = MUL_W'(p1_r) + (MUL_W'(p2_r) << 1);
        mul_b     = RECIP3;
        state_nxt = ST_COOL_WR;
      end
      ST_COOL_WR: begin
        row_ctl.shift = 1'b1;
        row_ctl.value = (cnt_r < IDX_W'(2)) ? cool_r : mul_prod[18:11];
        p2_nxt        = p1_r;
        p1_nxt        = cool_r;
        if (is_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_OUT_MUL;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_COOL_MUL;
        end
      end
      ST_OUT_MUL: begin
        row_ctl.shift = 1'b1;
        row_ctl.value = spark_val;
        mul_a         = MUL_W'(spark_val);
        mul_b         = HEAT_GAIN;
        state_nxt     = ST_OUT_RCP;
      end
      ST_OUT_RCP: begin
        mul_a     = mul_prod[MUL_W-1:0] + HEAT_ROUND;
        mul_b     = RECIP255;
        state_nxt = ST_OUT_EMIT;
      end
      ST_OUT_EMIT: begin
        out_valid_nxt = 1'b1;
        pix_nxt       = PIX_IDX_W'(cnt_r);
        rgb_nxt       = heat_rgb(mul_prod[30:23]);
        last_nxt      = is_last;
        if (is_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_OUT_MUL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      cnt_r          <= '0;
      cooling_rate_r <= COOL_W'(55);
      spark_chance_r <= CHANCE_W'(120);
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      cnt_r          <= cnt_nxt;
      cooling_rate_r <= cooling_rate_nxt;
      spark_chance_r <= spark_chance_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    lfsr_r     <= lfsr_nxt;
    mc1_r      <= mc1_nxt;
    cool_r     <= cool_nxt;
    p1_r       <= p1_nxt;
    p2_r       <= p2_nxt;
    spark_en_r <= spark_en_nxt;
    cell_r     <= cell_nxt;
    sheat_r    <= sheat_nxt;
    pix_r      <= pix_nxt;
    rgb_r      <= rgb_nxt;
    last_r     <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = pix_r;
  assign out_red         = rgb_r.red;
  assign out_green       = rgb_r.green;
  assign out_blue        = rgb_r.blue;
  assign out_last_pixel  = last_r;

`ifndef SYNTHESIS
  a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_OUT_EMIT))
    else $error("pixel word without an emit step");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted word did not start a frame");

  a_last_matches_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_pixel == (out_pixel_index == PIX_IDX_W'(NUM_CELLS - 1))))
    else $error("last flag does not match pixel index");

  a_no_cfg_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cfg_ready)
    else $error("configuration port open during a frame");
`endif

endmodule

@@ src/fhs_mul.sv @@
// ----------------------------------------------------------------------------
// fhs_mul: shared unsigned multiplier
// One 16 x 16 multiplier with a registered 32-bit product, time-shared by
// the sequencer for cooldown draws, division by three and color scaling.
// ----------------------------------------------------------------------------
module fhs_mul
  import fhs_pkg::*;
(
  input  logic              clk,
  input  logic [MUL_W-1:0]  op_a,
  input  logic [MUL_W-1:0]  op_b,
  output logic [PROD_W-1:0] prod
);

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
  end

  assign prod = prod_r;

endmodule

@@ src/fhs_div.sv @@
// ----------------------------------------------------------------------------
// fhs_div: division by a constant through a scaled reciprocal
// Loads the product of the dividend and a fixed reciprocal on start and flags
// the quotient in the cycle after start; used once per frame to derive the
// largest cooldown from the cooling rate.
// ----------------------------------------------------------------------------
module fhs_div #(
  parameter int unsigned DIVISOR = 32,
  parameter int unsigned DW      = 14
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  output logic          done,
  output logic [DW-1:0] quotient
);

  // With SHIFT = DW + clog2(DIVISOR) and RECIP = ceil(2^SHIFT / DIVISOR), the
  // rounding error times any DW-bit dividend stays below 2^SHIFT, so
  // (x * RECIP) >> SHIFT equals x / DIVISOR exactly.
  localparam int unsigned SHIFT   = DW + $clog2(DIVISOR);
  localparam int unsigned RECIP_W = DW + 2;
  localparam int unsigned FULL_W  = SHIFT + DW;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2**SHIFT + DIVISOR - 1) / DIVISOR);

  logic              done_r, done_nxt;
  logic [FULL_W-1:0] prod_r, prod_nxt;

  always_comb begin
    done_nxt = start;
    prod_nxt = prod_r;
    if (start) begin
      prod_nxt = FULL_W'(dividend) * FULL_W'(RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
    prod_r <= prod_nxt;
  end

  assign done     = done_r;
  assign quotient = prod_r[SHIFT +: DW];

endmodule

@@ src/fhs_heat_row.sv @@
// ----------------------------------------------------------------------------
// fhs_heat_row: rotating row of heat cells
// The cell under work is always at the head; each shift moves the next cell
// to the head and puts the updated value in at the tail.
// ----------------------------------------------------------------------------
module fhs_heat_row
  import fhs_pkg::*;
#(
  parameter int unsigned NUM_CELLS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  row_ctl_t          ctl,
  output logic [HEAT_W-1:0] head
);

  logic [HEAT_W-1:0] cells_r [NUM_CELLS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CELLS; k++) begin
        cells_r[k] <= '0;
      end
    end else if (ctl.shift) begin
      for (int k = 0; k < NUM_CELLS - 1; k++) begin
        cells_r[k] <= cells_r[k+1];
      end
      cells_r[NUM_CELLS-1] <= ctl.value;
    end
  end

  assign head = cells_r[0];

endmodule

@@ sim/tb_fire_heat_strip_effect_core.sv @@
// ----------------------------------------------------------------------------
// tb_fire_heat_strip_effect_core: self-checking bench for the fire strip core
// Sends frame words through the start/busy port and predicts every pixel word
// with an in-bench copy of the heat row. It covers register extremes, sparks,
// zero seeds and random frames with random gaps. Each pixel is compared field
// by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fire_heat_strip_effect_core;
  import fhs_pkg::*;

  localparam int unsigned NUM_CELLS   = 32;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned SETTLE      = 8;
  // Indexes that decode to no register.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct {
    logic [7:0]  roll;
    logic [2:0]  spot;
    logic [7:0]  heat;
    logic [15:0] seed;
  } frame_t;

  typedef struct {
    logic [PIX_IDX_W-1:0] index;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic                 last;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [7:0]            in_spark_roll = '0;
  logic [2:0]            in_spark_cell = '0;
  logic [7:0]            in_spark_heat = '0;
  logic [15:0]           in_cool_seed = '0;
  logic                  out_valid;
  logic [PIX_IDX_W-1:0]  out_pixel_index;
  logic [7:0]            out_red;
  logic [7:0]            out_green;
  logic [7:0]            out_blue;
  logic                  out_last_pixel;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Bench copy of the block state and registers.
  logic [7:0]  heat_row [NUM_CELLS];
  logic [9:0]  cool_rate_m;
  logic [8:0]  chance_m;
  pixel_t      pixel_q[$];

  int unsigned err_count = 0;
  int unsigned frames_sent = 0;
  int unsigned pixels_checked = 0;
  int unsigned settings_applied = 0;
  int unsigned quiet_cycles = 0;

  fire_heat_strip_effect_core #(
    .NUM_CELLS(NUM_CELLS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_spark_roll   (in_spark_roll),
    .in_spark_cell   (in_spark_cell),
    .in_spark_heat   (in_spark_heat),
    .in_cool_seed    (in_cool_seed),
    .out_valid       (out_valid),
    .out_pixel_index (out_pixel_index),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_last_pixel  (out_last_pixel),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Runs one frame on the bench heat row and queues the pixel words it yields.
  function automatic void render_frame(frame_t f);
    int unsigned lfsr;
    int unsigned maxcool;
    int unsigned draw;
    int unsigned sum;
    int unsigned t;
    int unsigned ramp;
    pixel_t      px;
    lfsr = 32'(f.seed);
    maxcool = (int'(cool_rate_m) * 10) / NUM_CELLS + 2;
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (lfsr[0]) begin
        lfsr = (lfsr >> 1) ^ 32'h0000_B400;
      end else begin
        lfsr = lfsr >> 1;
      end
      draw = (lfsr * (maxcool + 1)) >> 16;
      if (draw > heat_row[i]) begin
        heat_row[i] = 8'd0;
      end else begin
        heat_row[i] = heat_row[i] - draw[7:0];
      end
    end
    // Walk downward so each cell still sees the cooled values below it.
    for (int i = NUM_CELLS - 1; i >= 2; i--) begin
      sum = (int'(heat_row[i-1]) + 2 * int'(heat_row[i-2])) / 3;
      heat_row[i] = sum[7:0];
    end
    if (f.roll < chance_m) begin
      sum = int'(heat_row[f.spot]) + int'(f.heat);
      heat_row[f.spot] = (sum > 255) ? 8'd255 : sum[7:0];
    end
    for (int i = 0; i < NUM_CELLS; i++) begin
      t = (int'(heat_row[i]) * 191 + 127) / 255;
      ramp = ((t & 32'h3F) << 2) & 32'hFF;
      px.index = i[PIX_IDX_W-1:0];
      px.last = (i == NUM_CELLS - 1);
      if (t > T_HIGH) begin
        px.red = 8'hFF; px.green = 8'hFF; px.blue = ramp[7:0];
      end else if (t > T_MID) begin
        px.red = 8'hFF; px.green = ramp[7:0]; px.blue = 8'h00;
      end else begin
        px.red = ramp[7:0]; px.green = 8'h00; px.blue = 8'h00;
      end
      pixel_q.push_back(px);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 20);
    return $urandom_range(150, 320);
  endfunction

  // Mostly well-formed frames; the rest draw spark heat from the full range and a zero seed one time in four.
  function automatic frame_t random_frame();
    frame_t f;
    f.roll = 8'($urandom_range(0, 255));
    f.spot = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 99) < 85) begin
      f.heat = 8'($urandom_range(160, 255));
      f.seed = 16'($urandom_range(1, 65535));
    end else begin
      f.heat = 8'($urandom_range(0, 255));
      f.seed = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
    end
    return f;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  // Start stays high after acceptance unless a gap follows; the caller either
  // sends again at once or lowers it.
  task automatic send_frame(frame_t f);
    int unsigned gap;
    start <= 1'b1;
    in_spark_roll <= f.roll;
    in_spark_cell <= f.spot;
    in_spark_heat <= f.heat;
    in_cool_seed <= f.seed;
    do @(posedge clk); while (busy);
    render_frame(f);
    frames_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_fields(logic [7:0] roll, logic [2:0] spot, logic [7:0] heat,
                             logic [15:0] seed);
    frame_t f;
    f.roll = roll;
    f.spot = spot;
    f.heat = heat;
    f.seed = seed;
    send_frame(f);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pixel_q.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_COOLING_RATE) begin
      cool_rate_m = data;
    end else if (idx == REG_SPARK_CHANCE) begin
      chance_m = data[8:0];
    end
  endtask

  task automatic set_regs(logic [9:0] cool, logic [CFG_DATA_W-1:0] chance_data);
    wait_idle();
    write_reg(REG_COOLING_RATE, cool);
    write_reg(REG_SPARK_CHANCE, chance_data);
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  task automatic test_default_frames();
    send_fields(8'd119, 3'd0, 8'd255, 16'h0000);
    send_fields(8'd120, 3'd1, 8'd200, 16'hFFFF);
    send_fields(8'd0,   3'd7, 8'd160, 16'h0001);
    send_fields(8'd255, 3'd2, 8'd255, 16'h8000);
    send_fields(8'd5,   3'd4, 8'd170, 16'hACE1);
  endtask

  task automatic test_register_extremes();
    set_regs(10'd0, 10'd0);
    send_fields(8'd0, 3'd3, 8'd255, 16'h1234);
    send_fields(8'd0, 3'd6, 8'd255, 16'h0000);
    set_regs(10'd1023, 10'd256);
    send_fields(8'd255, 3'd3, 8'd200, 16'hFFFF);
    send_fields(8'd128, 3'd0, 8'd255, 16'h5A5A);
    send_fields(8'd255, 3'd7, 8'd160, 16'h0000);
    // Chance data with bit 9 set is masked to 511, so every roll sparks.
    set_regs(10'd0, 10'h3FF);
    for (int i = 0; i < 4; i++) begin
      send_fields(8'd255, 3'd5, 8'd255, (i % 2 == 0) ? 16'h0000 : 16'hC3A5);
    end
  endtask

  // Writes to unused indexes follow the real ones and must change nothing.
  task automatic test_unknown_index();
    wait_idle();
    write_reg(REG_COOLING_RATE, 10'd300);
    write_reg(REG_SPARK_CHANCE, 10'd200);
    write_reg(REG_SPARE_A, 10'h3FF);
    write_reg(REG_SPARE_B, 10'h155);
    cfg_valid <= 1'b0;
    settings_applied++;
    send_fields(8'd199, 3'd1, 8'd230, 16'h7777);
    send_fields(8'd200, 3'd2, 8'd230, 16'h9999);
  endtask

  task automatic test_low_spark_heat();
    set_regs(10'd0, 10'd256);
    send_fields(8'd10,  3'd0, 8'd0,   16'h0000);
    send_fields(8'd20,  3'd0, 8'd1,   16'h0000);
    send_fields(8'd30,  3'd4, 8'd159, 16'h0000);
    send_fields(8'd40,  3'd4, 8'd100, 16'h2468);
  endtask

  task automatic test_random_phases();
    logic [9:0]            cool;
    logic [CFG_DATA_W-1:0] chance_data;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          cool = 10'($urandom_range(0, 1023));
          chance_data = CFG_DATA_W'($urandom_range(0, 256));
        end
        1: begin cool = 10'd1023; chance_data = 10'd0; end
        2: begin cool = 10'd0; chance_data = 10'd256; end
        3: begin
          cool = 10'($urandom_range(0, 200));
          chance_data = CFG_DATA_W'($urandom_range(0, 1023));
        end
        default: begin
          cool = 10'($urandom_range(0, 1023));
          chance_data = CFG_DATA_W'($urandom_range(60, 200));
        end
      endcase
      set_regs(cool, chance_data);
      for (int i = 0; i < 18; i++) begin
        send_frame(random_frame());
      end
    end
  endtask

  // Every pixel word is compared with the oldest prediction.
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid) begin
      if (pixel_q.size() == 0) begin
        report_mismatch("unexpected pixel word, index", out_pixel_index, 0);
      end else begin
        want = pixel_q.pop_front();
        pixels_checked++;
        if (out_pixel_index !== want.index) report_mismatch("pixel_index", out_pixel_index, want.index);
        if (out_red !== want.red) report_mismatch("red", out_red, want.red);
        if (out_green !== want.green) report_mismatch("green", out_green, want.green);
        if (out_blue !== want.blue) report_mismatch("blue", out_blue, want.blue);
        if (out_last_pixel !== want.last) report_mismatch("last_pixel", out_last_pixel, want.last);
      end
    end
  end

  // Ends the run if no word moves on any port for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Stalled for %0d cycles with %0d pixels pending", quiet_cycles, pixel_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NUM_CELLS; i++) begin
      heat_row[i] = 8'd0;
    end
    cool_rate_m = 10'd55;
    chance_m = 9'd120;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    test_default_frames();
    test_register_extremes();
    test_unknown_index();
    test_low_spark_heat();
    test_random_phases();
    wait_idle();

    $display("Sent %0d frames under %0d register settings; checked %0d pixel words.",
             frames_sent, settings_applied, pixels_checked);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches found", err_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/fhs_pkg.sv
src/fhs_mul.sv
src/fhs_div.sv
src/fhs_heat_row.sv
src/fire_heat_strip_effect_core.sv
sim/tb_fire_heat_strip_effect_core.sv
